[sv/sha256_byte_stream_hasher_top_macros.svh]
// Assertion helpers for the checker file.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// Clocked check, muted while reset is held.
`define SBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define SBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sbh_pkg.sv]
// ----------------------------------------------------------------------------
// sbh_pkg
// Types, round constants and SHA-256 helper functions.
// ----------------------------------------------------------------------------
package sbh_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_WB,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } state_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

[sv/sha256_byte_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// Byte-stream SHA-256 engine with digest output one word per request.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the 64-byte block fills. A full
// block stops input while it is read, with the chaining value, out of the block
// and hash memories (ST_LOAD), compressed in 64 rounds (one per cycle, ST_ROUND)
// and added and written back to the hash (ST_WB). At end of message the pad and
// length are written one byte per cycle (up to 64, or 72 bytes with an
// extra block), each resulting block is compressed as above, and the eight
// digest words follow, each read, captured and held until the sink takes it.
// in_tready is high only between these phases.
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);
  import sbh_pkg::*;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r;
  logic [5:0]  fill_r;
  logic [23:0] acc_r;
  logic [63:0] bits_r;
  logic        fin_r, p80_r, lenph_r, fresh_r;
  logic [2:0]  oidx_r;
  logic [31:0] out_word_r;

  logic [31:0] buf_mem  [16];
  logic [31:0] hash_mem [8];
  logic [31:0] buf_rd_r, hash_rd_r;
  logic [2:0]  hash_ra;

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];

  logic        byte_en, count_msg, fin_set, p80_set, len_set, msg_done;
  logic [7:0]  byte_val;
  logic [63:0] bits_sh;
  logic [2:0]  prev_idx;
  logic [31:0] hash_base, t1, t2, w_new;

  assign bits_sh   = bits_r >> {~fill_r[2:0], 3'b000};
  assign prev_idx  = cnt_r[2:0] - 3'd1;
  assign hash_base = fresh_r ? InitHash[prev_idx] : hash_rd_r;
  assign hash_ra   = (state_r == ST_OUT_RD) ? oidx_r : cnt_r[2:0];

  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + RoundK[cnt_r] + w_r[0];
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT_WAIT);
  assign out_tdata  = out_word_r;
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    byte_en   = 1'b0;
    byte_val  = in_tdata;
    count_msg = 1'b0;
    fin_set   = 1'b0;
    p80_set   = 1'b0;
    len_set   = 1'b0;
    msg_done  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          priority case (in_tuser)
            KIND_BYTE: begin
              byte_en   = 1'b1;
              count_msg = 1'b1;
            end
            KIND_FINAL: begin
              byte_en   = 1'b1;
              count_msg = 1'b1;
              fin_set   = 1'b1;
            end
            KIND_END: fin_set = 1'b1;
            default: ;
          endcase
          if (byte_en && fill_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end else if (fin_set) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        byte_en = 1'b1;
        if (!p80_r) begin
          byte_val = PadByte;
          p80_set  = 1'b1;
        end else if (lenph_r || fill_r == LenPos) begin
          byte_val = bits_sh[7:0];
          len_set  = 1'b1;
        end else begin
          byte_val = 8'h00;
        end
        if (fill_r == 6'd63) state_nxt = ST_LOAD;
      end
      ST_LOAD:  if (cnt_r == 6'd16) state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_r == 6'd63) state_nxt = ST_WB;
      ST_WB: begin
        if (cnt_r == 6'd8) begin
          if (!fin_r)       state_nxt = ST_IDLE;
          else if (lenph_r) state_nxt = ST_OUT_RD;
          else              state_nxt = ST_PAD;
        end
      end
      ST_OUT_RD:  state_nxt = ST_OUT_CAP;
      ST_OUT_CAP: state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_tready) begin
          if (oidx_r == 3'd7) begin
            state_nxt = ST_IDLE;
            msg_done  = 1'b1;
          end else begin
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fill_r  <= '0;
      bits_r  <= '0;
      fin_r   <= 1'b0;
      p80_r   <= 1'b0;
      lenph_r <= 1'b0;
      fresh_r <= 1'b1;
      oidx_r  <= '0;
    end else begin
      cnt_r <= (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;
      if (byte_en)   fill_r <= fill_r + 6'd1;
      if (count_msg) bits_r <= bits_r + 64'd8;
      if (fin_set)   fin_r <= 1'b1;
      if (p80_set)   p80_r <= 1'b1;
      if (len_set)   lenph_r <= 1'b1;
      if (state_r == ST_WB && cnt_r == 6'd8) fresh_r <= 1'b0;
      if (state_r == ST_OUT_WAIT && out_tready) oidx_r <= oidx_r + 3'd1;
      if (msg_done) begin
        bits_r  <= '0;
        fill_r  <= '0;
        fin_r   <= 1'b0;
        p80_r   <= 1'b0;
        lenph_r <= 1'b0;
        fresh_r <= 1'b1;
      end
    end
  end

  // block buffer: bytes gather into a word, written every fourth byte
  always_ff @(posedge clk) begin
    if (byte_en) begin
      acc_r <= {acc_r[15:0], byte_val};
      if (fill_r[1:0] == 2'd3) buf_mem[fill_r[5:2]] <= {acc_r, byte_val};
    end
    buf_rd_r <= buf_mem[cnt_r[3:0]];
  end

  // chaining value; reads before first write come from the IV via fresh_r
  always_ff @(posedge clk) begin
    if (state_r == ST_WB && cnt_r != 6'd0) hash_mem[prev_idx] <= hash_base + v_r[0];
    hash_rd_r <= hash_mem[hash_ra];
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && cnt_r != 6'd0) begin
      for (int k = 0; k < 15; k++) w_r[k] <= w_r[k+1];
      w_r[15] <= buf_rd_r;
      if (cnt_r <= 6'd8) begin
        for (int k = 0; k < 7; k++) v_r[k] <= v_r[k+1];
        v_r[7] <= hash_base;
      end
    end else if (state_r == ST_ROUND) begin
      for (int k = 0; k < 15; k++) w_r[k] <= w_r[k+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (state_r == ST_WB && cnt_r != 6'd0) begin
      for (int k = 0; k < 7; k++) v_r[k] <= v_r[k+1];
      v_r[7] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT_CAP) out_word_r <= hash_rd_r;
  end

endmodule

[sv/sbh_checker.sv]
// ----------------------------------------------------------------------------
// sbh_checker
// Port-level checks on the hasher's input and digest channels.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_top_macros.svh"

module sbh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  // final digest word carries the last index
  `SBH_ASSERT(a_last_idx, (out_tvalid && out_tlast) |-> (out_tuser == 3'd7), "last word index")
  // no new request taken while a digest is being delivered
  `SBH_ASSERT(a_excl, !(out_tvalid && in_tready), "input open during digest")
  // after a non-final word the next word follows, input stays closed
  `SBH_ASSERT(a_more, (out_tvalid && out_tready && !out_tlast) |=> !in_tready,
    "input opened mid digest")
  // stalled digest word holds
  `SBH_ASSERT(a_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)),
    "stalled word changed")
endmodule

bind sha256_byte_stream_hasher_top sbh_checker u_sbh_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
